@@ design/sha256_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned LenOffset  = 56;
	localparam logic [7:0]  PadByte    = 8'h80;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} state_t;

	// Handshake from the sequencer to the round unit, and status back.
	typedef struct packed {
		logic start;
	} comp_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} comp_stat_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ design/sha256_stream_if.sv @@
// Valid/ready stream interface with a generic payload.
interface sha256_stream_if #(
	parameter int unsigned W = 8
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/sha256_round.sv @@
// Round unit: message schedule window and one compression round per cycle.
module sha256_round (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sha256_pkg::comp_ctrl_t    ctrl,
	input  logic [511:0]              block,
	input  sha256_pkg::word_t [7:0]   h_in,
	output sha256_pkg::comp_stat_t    stat,
	output sha256_pkg::word_t [7:0]   v_out
);
	sha256_pkg::word_t [15:0] w_q;
	sha256_pkg::word_t [7:0]  v_q;
	logic [5:0]               t_q;
	logic                     busy_q;
	logic                     done_q;

	sha256_pkg::word_t w_new, s0, s1, big0, big1, chs, mj, t1, t2, wt;

	always_comb begin
		wt   = w_q[0];
		s0   = sha256_pkg::ror(w_q[1], 7) ^ sha256_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = sha256_pkg::ror(w_q[14], 17) ^ sha256_pkg::ror(w_q[14], 19)
		       ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		big1 = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
		       ^ sha256_pkg::ror(v_q[4], 25);
		chs  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + chs + sha256_pkg::round_k(t_q) + wt;
		big0 = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
		       ^ sha256_pkg::ror(v_q[0], 22);
		mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			t_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				t_q    <= '0;
			end else if (busy_q) begin
				t_q <= t_q + 6'd1;
				if (t_q == 6'(sha256_pkg::Rounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Word 0 of the window is the current round's schedule word.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[511-32*i -: 32];
			end
			v_q <= h_in;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign v_out     = v_q;

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held two cycles");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctrl.start) else $error("start while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("done without rounds");
endmodule

@@ design/sha256_stream_hasher_top.sv @@
// Top level: byte gathering, padding sequencer, hash state and digest output.
//
// Channel | Dir | Payload
// in_ch   | in  | {message_end, has_byte, data_byte}
// out_ch  | out | {last_word, word_index, digest_word}
//
// The 64th byte of a block loads the round unit in the next cycle, which runs
// 64 rounds and raises done, and then the ADD state adds into the hash words.
// A message end pads before each padding compression, runs one or two of
// them, then shows the eight digest words, one per taken transaction. Input is
// not ready during compression or output. Reset is asynchronous and restores
// the initial hash.
module sha256_stream_hasher_top (
	input logic                clk,
	input logic                arst_n,
	sha256_stream_if.sink      in_ch,
	sha256_stream_if.source    out_ch
);
	sha256_pkg::state_t       state_q, state_d;
	sha256_pkg::word_t [7:0]  h_q;
	sha256_pkg::word_t        buf_q [16];
	logic [5:0]               fill_q;
	logic [63:0]              len_q;
	logic                     final_q;   // compression in flight is the last one
	logic                     second_q;  // padding needs another block after this
	logic [2:0]               oidx_q;
	logic [511:0]             block;
	sha256_pkg::comp_ctrl_t   cctrl;
	sha256_pkg::comp_stat_t   cstat;
	sha256_pkg::word_t [7:0]  v;

	logic [7:0]  d_byte;
	logic        d_has, d_end, acc;

	assign d_byte = in_ch.payload[7:0];
	assign d_has  = in_ch.payload[8];
	assign d_end  = in_ch.payload[9];
	assign acc    = in_ch.valid && in_ch.ready;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			block[511-32*i -: 32] = buf_q[i];
		end
	end

	sha256_round u_round (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cctrl),
		.block (block),
		.h_in  (h_q),
		.stat  (cstat),
		.v_out (v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sha256_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// The round unit loads from the LOAD state, which follows the last buffer write.
	always_comb begin
		state_d     = state_q;
		cctrl.start = 1'b0;
		in_ch.ready = 1'b0;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (acc) begin
					if (d_has && fill_q == 6'd63) begin
						state_d = sha256_pkg::ST_LOAD;
					end else if (d_end) begin
						state_d = sha256_pkg::ST_PAD;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				state_d = sha256_pkg::ST_LOAD;
			end
			sha256_pkg::ST_LOAD: begin
				cctrl.start = 1'b1;
				state_d = sha256_pkg::ST_COMP;
			end
			sha256_pkg::ST_COMP: begin
				if (cstat.done) state_d = sha256_pkg::ST_ADD;
			end
			sha256_pkg::ST_ADD: begin
				if (second_q)     state_d = sha256_pkg::ST_PAD;
				else if (final_q) state_d = sha256_pkg::ST_OUT;
				else              state_d = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_OUT: begin
				if (out_ch.ready && oidx_q == 3'd7) state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			len_q    <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			oidx_q   <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
		end else begin
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (acc) begin
						if (d_has) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'd8;
						end
						if (d_end) begin
							final_q <= !(d_has && fill_q == 6'd63);
							second_q <= 1'b0;
						end else begin
							final_q <= 1'b0;
						end
						// A full block with end pending pads after that compression.
						if (d_end && d_has && fill_q == 6'd63) second_q <= 1'b1;
					end
				end
				sha256_pkg::ST_PAD: begin
					// Pad byte lands at fill; length fits if fill stays below 56.
					if (!final_q) begin
						final_q  <= 1'b1;
						second_q <= 1'b0;
					end else if (fill_q >= 6'(sha256_pkg::LenOffset)) begin
						second_q <= 1'b1;
					end else begin
						second_q <= 1'b0;
					end
					fill_q <= '0;
				end
				sha256_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v[i];
					if (!final_q && second_q) begin
						// Full block was last data; padding goes in an empty block.
						final_q  <= 1'b1;
						second_q <= 1'b0;
						fill_q   <= '0;
					end
				end
				sha256_pkg::ST_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							fill_q   <= '0;
							len_q    <= '0;
							final_q  <= 1'b0;
							second_q <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Pad pass tracks whether the 0x80 byte has already been placed.
	logic pad_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_done_q <= 1'b0;
		end else if (state_q == sha256_pkg::ST_PAD) begin
			pad_done_q <= 1'b1;
		end else if (state_q == sha256_pkg::ST_OUT) begin
			pad_done_q <= 1'b0;
		end
	end

	// Block buffer: byte writes, and in ST_PAD a padding fill of the bytes from fill upward.
	always_ff @(posedge clk) begin
		if (state_q == sha256_pkg::ST_IDLE && acc && d_has) begin
			buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b111} -: 8] <= d_byte;
		end else if (state_q == sha256_pkg::ST_PAD) begin
			for (int w = 0; w < 16; w++) begin
				for (int j = 0; j < 4; j++) begin
					if (6'(4*w+j) > fill_q || (6'(4*w+j) == fill_q && pad_done_q)) begin
						buf_q[w][31-8*j -: 8] <= 8'h00;
					end
					if (6'(4*w+j) == fill_q && !pad_done_q && !(fill_q == 6'd0
					    && !final_q && second_q)) begin
						buf_q[w][31-8*j -: 8] <= sha256_pkg::PadByte;
					end
				end
			end
			if (pad_done_q || fill_q < 6'(sha256_pkg::LenOffset)) begin
				buf_q[14] <= len_q[63:32];
				buf_q[15] <= len_q[31:0];
			end
		end
	end

	assign out_ch.valid   = (state_q == sha256_pkg::ST_OUT);
	assign out_ch.payload = {oidx_q == 3'd7, oidx_q, h_q[oidx_q]};

	a_in_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("input open during output");
	a_out_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && oidx_q == 3'd7 |=> state_q == sha256_pkg::ST_IDLE)
		else $error("digest did not finish");
	a_pad_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha256_pkg::ST_PAD |-> ##2 cstat.busy) else $error("pad did not compress");
endmodule

@@ tb/sha256_stream_checker.sv @@
// Checker that predicts SHA-256 digests from the input stream and compares the output words.
module sha256_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [9:0]  in_payload,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [35:0] out_payload,
	output int          fail_count,
	output int          pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        last_word;
		logic [2:0]  word_index;
		logic [31:0] digest_word;
	} digest_word_t;

	digest_word_t      expected_words[$];
	sha256_pkg::word_t hash_state[8];
	logic [7:0]        msg_block[64];
	int unsigned       fill_count;
	logic [63:0]       msg_bits;

	function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic sha256_pkg::word_t k_const(int unsigned t);
		sha256_pkg::word_t kt[64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return kt[t];
	endfunction

	task automatic restart_hash();
		hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill_count = 0;
		msg_bits = '0;
	endtask

	task automatic compress_msg_block();
		sha256_pkg::word_t w[64];
		sha256_pkg::word_t v[8];
		sha256_pkg::word_t s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic absorb_transaction(logic [9:0] p);
		if (p[8]) begin
			msg_block[fill_count] = p[7:0];
			fill_count++;
			msg_bits += 64'd8;
			if (fill_count == sha256_pkg::BlockBytes) begin
				compress_msg_block();
				fill_count = 0;
			end
		end
		if (p[9]) begin
			msg_block[fill_count] = sha256_pkg::PadByte;
			fill_count++;
			if (fill_count > sha256_pkg::LenOffset) begin
				for (int i = fill_count; i < 64; i++)
					msg_block[i] = 8'h00;
				compress_msg_block();
				fill_count = 0;
			end
			for (int i = fill_count; i < sha256_pkg::LenOffset; i++)
				msg_block[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				msg_block[sha256_pkg::LenOffset + i] = msg_bits[63 - 8*i -: 8];
			compress_msg_block();
			for (int i = 0; i < 8; i++)
				expected_words.push_back('{last_word: i == 7, word_index: 3'(i),
					digest_word: hash_state[i]});
			restart_hash();
		end
	endtask

	always @(posedge clk) begin
		digest_word_t got, want;
		if (!arst_n) begin
			restart_hash();
			expected_words.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = out_payload;
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digest transaction %h", got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"digest mismatch: expected word %h idx %0d last %b,",
								" got %h idx %0d last %b"},
								want.digest_word, want.word_index, want.last_word,
								got.digest_word, got.word_index, got.last_word);
					end
				end
			end
			if (in_valid && in_ready)
				absorb_transaction(in_payload);
		end
		pending_words = expected_words.size();
	end
endmodule

@@ tb/tb_sha256_stream_hasher_top.sv @@
// Testbench top: drives byte stream transactions and reports the verdict.
module tb_sha256_stream_hasher_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending_words;
	int   src_idle_pct = 17, snk_idle_pct = 48;
	bit   hold_sink = 0;
	longint cycle_count = 0;

	sha256_stream_if #(.W(10)) in_ch ();
	sha256_stream_if #(.W(36)) out_ch ();

	sha256_stream_hasher_top uut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	sha256_stream_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_payload(in_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload),
		.fail_count(fail_count), .pending_words(pending_words));

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: random idling, or a long hold-off when requested.
	always @(posedge clk) begin
		if (!arst_n || hold_sink)
			out_ch.ready <= 0;
		else
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Offers one transaction, with random gaps before it, and waits until taken.
	// Valid stays high afterwards; the next call or the caller drops it.
	task automatic send_item(logic [7:0] b, logic hb, logic me);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.payload <= {me, hb, b};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 0;
		while (pending_words != 0) @(posedge clk);
	endtask

	task automatic send_message(int len, int mode);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
			if ($urandom_range(9) == 0)
				send_item(8'($urandom), 0, 0);
			send_item(b, 1, (i == len - 1) && $urandom_range(1));
		end
		send_item(8'($urandom), 0, 1);
	endtask

	initial begin
		int n;
		in_ch.valid <= 0;
		in_ch.payload <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty message, idle item, single bytes, extremes, block edges.
		send_item(8'h00, 0, 1);
		send_item(8'h5a, 0, 0);
		send_item(8'hff, 1, 1);
		send_item(8'h00, 1, 1);
		send_item(8'h61, 1, 0);
		send_item(8'h62, 1, 0);
		send_item(8'h63, 1, 1);
		send_message(55, 1);
		send_message(56, 2);
		send_message(64, 0);
		wait_drained();
		// Long receiver hold-off while the sender keeps offering.
		fork
			begin
				hold_sink = 1;
				repeat (400) @(posedge clk);
				hold_sink = 0;
			end
			begin
				send_item(8'h11, 1, 1);
				send_item(8'h22, 1, 1);
				send_item(8'h33, 1, 1);
				in_ch.valid <= 0;
			end
		join
		wait_drained();
		n = 0;
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 48 : 0;
			snk_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 17 : 0;
			while (n < 50 * (ph + 1)) begin
				int len;
				len = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(12);
				send_message(len, 0);
				n += len + 1;
			end
			wait_drained();
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
